[rtl/ultrasonic_echo_ranger_core_defines.svh]
// Assertion helpers shared by the ranger RTL.
`ifndef ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UER_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("uer check failed");

// Next-cycle implication, checked outside reset.
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("uer check failed");

`endif

[rtl/uer_pkg.sv]
`timescale 1ns / 1ps

package uer_pkg;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_ECHO  = 2'd1;
    localparam logic [1:0] STAT_TOO_LONG = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CM_PER_TICK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE  = 3'd5;

    typedef struct packed {
        logic [15:0] trigger_ticks;
        logic [15:0] clear_ticks;
        logic [15:0] rise_timeout_ticks;
        logic [15:0] echo_limit_ticks;
        logic [15:0] cm_per_tick_q16;
        logic [15:0] max_distance_cm;
    } t_cfg;

    typedef struct packed {
        logic start_req;
        logic echo_in;
    } t_in_word;

    typedef struct packed {
        logic        trig_out;
        logic        echo_drive_low;
        logic        busy_res;
        logic        done_res;
        logic [15:0] distance_cm;
        logic [1:0]  status;
    } t_out_word;

    // Per-tick flags handed from the sequencer to the scaling stage.
    typedef struct packed {
        logic       trig_out;
        logic       echo_drive_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } t_flags;

endpackage

[rtl/uer_if.sv]
`timescale 1ns / 1ps

interface uer_in_if;
    logic               valid;
    logic               ready;
    uer_pkg::t_in_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface uer_out_if;
    logic               valid;
    logic               ready;
    uer_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/ultrasonic_echo_ranger_core.sv]
`timescale 1ns / 1ps

// Pulse-echo range controller for a trigger/echo ultrasonic sensor. Each input word is one
// timebase tick carrying a start request and the sampled echo level; each input word yields
// exactly one result word with the trigger and echo-clear pin levels, a busy flag, and on the
// tick a measurement ends a done flag, the distance in centimeters and a status (ok, echo
// never rose, echo too long). The block takes one word every clock cycle while results are
// being taken, and offers each result word from the output register. Each word in turn
// passes an input register, the sequencer register (which also holds the count-times-scale
// product from a single COUNT_WIDTH x 16 multiplier) and the clip/output register. Each stage
// holds its word when the stage ahead is full and held, so input keeps flowing into empty
// stages while a result waits to be taken. Configuration registers are written through
// i_cfg_we/i_cfg_idx/i_cfg_wdata and should only change while no measurement and no word is
// in flight.

`include "ultrasonic_echo_ranger_core_defines.svh"

module ultrasonic_echo_ranger_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [15:0]                     i_cfg_wdata,
    uer_in_if.sink                          i_in,
    uer_out_if.source                       o_res
);
    import uer_pkg::*;

    // Configuration registers, loaded with their documented reset values.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks      <= 16'd25;
            r_cfg.clear_ticks        <= 16'd2500;
            r_cfg.rise_timeout_ticks <= 16'd25000;
            r_cfg.echo_limit_ticks   <= 16'd60000;
            r_cfg.cm_per_tick_q16    <= 16'd450;
            r_cfg.max_distance_cm    <= 16'd400;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TRIGGER_TICKS: r_cfg.trigger_ticks      <= i_cfg_wdata;
                REG_CLEAR_TICKS:   r_cfg.clear_ticks        <= i_cfg_wdata;
                REG_RISE_TIMEOUT:  r_cfg.rise_timeout_ticks <= i_cfg_wdata;
                REG_ECHO_LIMIT:    r_cfg.echo_limit_ticks   <= i_cfg_wdata;
                REG_CM_PER_TICK:   r_cfg.cm_per_tick_q16    <= i_cfg_wdata;
                REG_MAX_DISTANCE:  r_cfg.max_distance_cm    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Stage valid bits: input register, sequencer register, output register.
    logic     r_v1, r_v2, r_v3;
    t_in_word r_in;
    logic     rdy1, rdy2, rdy3;
    logic     acc, mv12, mv23;

    assign rdy3 = !r_v3 || o_res.ready;
    assign mv23 = r_v2 && rdy3;
    assign rdy2 = !r_v2 || rdy3;
    assign mv12 = r_v1 && rdy2;
    assign rdy1 = !r_v1 || rdy2;
    assign acc  = i_in.valid && rdy1;

    assign i_in.ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (acc) begin
                r_v1 <= 1'b1;
            end else if (mv12) begin
                r_v1 <= 1'b0;
            end
            if (mv12) begin
                r_v2 <= 1'b1;
            end else if (mv23) begin
                r_v2 <= 1'b0;
            end
            if (mv23) begin
                r_v3 <= 1'b1;
            end else if (o_res.ready) begin
                r_v3 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_in <= i_in.data;
        end
    end

    // The sequencer advances exactly once per word, when that word leaves the input register.
    t_flags                  seq_flags;
    logic [COUNT_WIDTH+15:0] seq_prod;

    uer_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (mv12),
        .i_start (r_in.start_req),
        .i_echo  (r_in.echo_in),
        .i_cfg   (r_cfg),
        .o_flags (seq_flags),
        .o_prod  (seq_prod)
    );

    uer_scale #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_scale (
        .i_clk    (i_clk),
        .i_load   (mv23),
        .i_flags  (seq_flags),
        .i_prod   (seq_prod),
        .i_max_cm (r_cfg.max_distance_cm),
        .o_word   (o_res.data)
    );

    assign o_res.valid = r_v3;

    `UER_ASSERT_IMPL(a_done_not_busy, i_clk, i_rst_n, o_res.valid && o_res.data.done_res, !o_res.data.busy_res)
    `UER_ASSERT_IMPL(a_status_needs_done, i_clk, i_rst_n, o_res.valid && (o_res.data.status != STAT_OK), o_res.data.done_res)
    `UER_ASSERT_IMPL(a_idle_distance_zero, i_clk, i_rst_n, o_res.valid && !o_res.data.done_res, o_res.data.distance_cm == 16'd0)

endmodule

[rtl/uer_ctrl.sv]
`timescale 1ns / 1ps

`include "ultrasonic_echo_ranger_core_defines.svh"

module uer_ctrl #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic                    i_start,
    input  logic                    i_echo,
    input  uer_pkg::t_cfg           i_cfg,
    output uer_pkg::t_flags         o_flags,
    output logic [COUNT_WIDTH+15:0] o_prod
);
    import uer_pkg::*;

    localparam int CMPW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int PW   = COUNT_WIDTH + 16;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CLEAR,
        PH_TRIG,
        PH_WAIT,
        PH_COUNT
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    t_flags                 r_flags, n_flags;
    logic [PW-1:0]          r_prod;

    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [CMPW-1:0]        cur_x, inc_x;
    logic                   full_cur, full_inc;

    assign cnt_inc  = COUNT_WIDTH'(r_cnt + 1'b1);
    assign cur_x    = CMPW'(r_cnt);
    assign inc_x    = CMPW'(cnt_inc);
    assign full_cur = &r_cnt;
    assign full_inc = &cnt_inc;

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_flags = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_cnt   = '0;
                    n_phase = (i_echo && (i_cfg.clear_ticks != 16'd0)) ? PH_CLEAR : PH_TRIG;
                end
            end
            PH_CLEAR: begin
                n_flags.echo_drive_low = 1'b1;
                n_cnt = cnt_inc;
                if ((inc_x >= CMPW'(i_cfg.clear_ticks)) || full_inc) begin
                    n_cnt   = '0;
                    n_phase = PH_TRIG;
                end
            end
            PH_TRIG: begin
                n_flags.trig_out = 1'b1;
                n_cnt = cnt_inc;
                if ((inc_x >= CMPW'(i_cfg.trigger_ticks)) || full_inc) begin
                    n_cnt   = '0;
                    n_phase = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (i_echo) begin
                    n_cnt   = '0;
                    n_phase = PH_COUNT;
                end else if ((cur_x >= CMPW'(i_cfg.rise_timeout_ticks)) || full_cur) begin
                    n_flags.done_res = 1'b1;
                    n_flags.status   = STAT_NO_ECHO;
                    n_cnt   = '0;
                    n_phase = PH_IDLE;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_COUNT: begin
                if (!i_echo) begin
                    n_flags.done_res = 1'b1;
                    n_flags.status   = STAT_OK;
                    n_phase = PH_IDLE;
                end else if ((cur_x >= CMPW'(i_cfg.echo_limit_ticks)) || full_cur) begin
                    n_flags.done_res = 1'b1;
                    n_flags.status   = STAT_TOO_LONG;
                    n_cnt   = '0;
                    n_phase = PH_IDLE;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            default: begin
                n_cnt   = '0;
                n_phase = PH_IDLE;
            end
        endcase
        n_flags.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_flags <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_flags <= n_flags;
        end
    end

    // The echo count before this tick's update is what a good finish scales.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_prod <= PW'(r_cnt) * PW'(i_cfg.cm_per_tick_q16);
        end
    end

    assign o_flags = r_flags;
    assign o_prod  = r_prod;

    `UER_ASSERT_NEXT(a_trig_exit, i_clk, i_rst_n, i_step && (r_phase == PH_TRIG), (r_phase == PH_TRIG) || (r_phase == PH_WAIT))
    `UER_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, r_flags.done_res, r_phase == PH_IDLE)
    `UER_ASSERT_IMPL(a_busy_phase, i_clk, i_rst_n, r_flags.busy_res, r_phase != PH_IDLE)

endmodule

[rtl/uer_scale.sv]
`timescale 1ns / 1ps

module uer_scale #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_load,
    input  uer_pkg::t_flags         i_flags,
    input  logic [COUNT_WIDTH+15:0] i_prod,
    input  logic [15:0]             i_max_cm,
    output uer_pkg::t_out_word      o_word
);
    import uer_pkg::*;

    localparam int CMPW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [COUNT_WIDTH-1:0] whole_cm;
    logic [15:0]            clip_cm;
    t_out_word              r_word, n_word;

    // Drop the sixteen fraction bits, then clip to the configured ceiling.
    assign whole_cm = i_prod[COUNT_WIDTH+15:16];
    assign clip_cm  = (CMPW'(whole_cm) > CMPW'(i_max_cm)) ? i_max_cm
                                                          : 16'(CMPW'(whole_cm));

    always_comb begin
        n_word.trig_out       = i_flags.trig_out;
        n_word.echo_drive_low = i_flags.echo_drive_low;
        n_word.busy_res       = i_flags.busy_res;
        n_word.done_res       = i_flags.done_res;
        n_word.status         = i_flags.status;
        if (!i_flags.done_res) begin
            n_word.distance_cm = 16'd0;
        end else if (i_flags.status == STAT_OK) begin
            n_word.distance_cm = clip_cm;
        end else begin
            n_word.distance_cm = i_max_cm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

[verif/ultrasonic_echo_ranger_core_tb.sv]
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_core_tb;
    import uer_pkg::*;

    localparam int COUNT_WIDTH   = 16;
    // Stretch of cycles with no handshake on either channel that counts as a hang. The
    // longest legal quiet stretch is the forced receiver hold plus a drain and a settle pause.
    localparam int STALL_LIMIT   = 2000;
    // Forced receiver hold that fills the pipeline and pushes back on the input channel.
    localparam int HOLD_CYCLES   = 300;
    // Pause after the last result before a register write or the end of the run; the block
    // is three register stages deep.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_WORDS  = 950;

    typedef enum logic [2:0] {
        RANGE_IDLE,
        RANGE_CLEAR,
        RANGE_TRIGGER,
        RANGE_WAIT,
        RANGE_COUNT
    } range_phase_e;

    // Tracks the ranger's sequencer and settings, turns every accepted tick word into the
    // result word it must produce, and checks the result words in order.
    class echo_ranger_checker;
        t_cfg                   regs;
        range_phase_e           phase;
        logic [COUNT_WIDTH-1:0] ticks;
        t_out_word              expected_words[$];
        int                     failures;
        int                     results_seen;

        function new();
            regs.trigger_ticks      = 16'd25;
            regs.clear_ticks        = 16'd2500;
            regs.rise_timeout_ticks = 16'd25000;
            regs.echo_limit_ticks   = 16'd60000;
            regs.cm_per_tick_q16    = 16'd450;
            regs.max_distance_cm    = 16'd400;
            phase        = RANGE_IDLE;
            ticks        = '0;
            failures     = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                REG_TRIGGER_TICKS: regs.trigger_ticks      = val;
                REG_CLEAR_TICKS:   regs.clear_ticks        = val;
                REG_RISE_TIMEOUT:  regs.rise_timeout_ticks = val;
                REG_ECHO_LIMIT:    regs.echo_limit_ticks   = val;
                REG_CM_PER_TICK:   regs.cm_per_tick_q16    = val;
                REG_MAX_DISTANCE:  regs.max_distance_cm    = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Advances the sequencer by one tick and queues the result word of that tick.
        function void take_tick(t_in_word w);
            t_out_word   o;
            logic [31:0] product;
            o = '0;
            case (phase)
                RANGE_IDLE: begin
                    if (w.start_req) begin
                        ticks = '0;
                        phase = (w.echo_in && regs.clear_ticks != 0) ? RANGE_CLEAR
                                                                      : RANGE_TRIGGER;
                    end
                end
                RANGE_CLEAR: begin
                    o.echo_drive_low = 1'b1;
                    ticks = ticks + 1'b1;
                    if (ticks >= regs.clear_ticks || ticks == '1) begin
                        ticks = '0;
                        phase = RANGE_TRIGGER;
                    end
                end
                RANGE_TRIGGER: begin
                    o.trig_out = 1'b1;
                    ticks = ticks + 1'b1;
                    if (ticks >= regs.trigger_ticks || ticks == '1) begin
                        ticks = '0;
                        phase = RANGE_WAIT;
                    end
                end
                RANGE_WAIT: begin
                    if (w.echo_in) begin
                        ticks = '0;
                        phase = RANGE_COUNT;
                    end else if (ticks >= regs.rise_timeout_ticks || ticks == '1) begin
                        o.done_res    = 1'b1;
                        o.status      = STAT_NO_ECHO;
                        o.distance_cm = regs.max_distance_cm;
                        ticks = '0;
                        phase = RANGE_IDLE;
                    end else begin
                        ticks = ticks + 1'b1;
                    end
                end
                RANGE_COUNT: begin
                    if (!w.echo_in) begin
                        product       = 32'(ticks) * 32'(regs.cm_per_tick_q16);
                        o.done_res    = 1'b1;
                        o.status      = STAT_OK;
                        o.distance_cm = (product[31:16] > regs.max_distance_cm)
                                        ? regs.max_distance_cm : product[31:16];
                        phase = RANGE_IDLE;
                    end else if (ticks >= regs.echo_limit_ticks || ticks == '1) begin
                        o.done_res    = 1'b1;
                        o.status      = STAT_TOO_LONG;
                        o.distance_cm = regs.max_distance_cm;
                        ticks = '0;
                        phase = RANGE_IDLE;
                    end else begin
                        ticks = ticks + 1'b1;
                    end
                end
                default: begin
                    ticks = '0;
                    phase = RANGE_IDLE;
                end
            endcase
            o.busy_res = (phase != RANGE_IDLE);
            expected_words.push_back(o);
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            results_seen++;
            if (expected_words.size() == 0) begin
                if (failures < 10)
                    $display("result word %0d arrived with nothing expected", results_seen);
                failures++;
                return;
            end
            want = expected_words.pop_front();
            if (got.trig_out !== want.trig_out || got.echo_drive_low !== want.echo_drive_low
                || got.busy_res !== want.busy_res || got.done_res !== want.done_res
                || got.distance_cm !== want.distance_cm || got.status !== want.status) begin
                if (failures < 10) begin
                    $display("result word %0d mismatch: expected trig=%0b clr=%0b busy=%0b",
                             results_seen, want.trig_out, want.echo_drive_low, want.busy_res);
                    $display("    done=%0b dist=%0d status=%0d, actual trig=%0b clr=%0b",
                             want.done_res, want.distance_cm, want.status,
                             got.trig_out, got.echo_drive_low);
                    $display("    busy=%0b done=%0b dist=%0d status=%0d",
                             got.busy_res, got.done_res, got.distance_cm, got.status);
                end
                failures++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [15:0]          cfg_wdata;

    uer_in_if  in_if ();
    uer_out_if res_if ();

    ultrasonic_echo_ranger_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_res       (res_if)
    );

    echo_ranger_checker ranger = new();

    // When idle_on is clear, both channels run flat out. hold_req asks the result side for
    // one long hold-off, which it times on its own.
    bit idle_on;
    bit hold_req;
    int send_run;
    int words_sent;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result side: takes result words with bursts of back-pressure and checks each one.
    // Values are sampled right at the rising edge, before any of this edge's updates land.
    initial begin : result_side
        int stall_left;
        int run_left;
        int hold_left;
        stall_left = 0;
        run_left   = 0;
        hold_left  = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
                ranger.check_word(res_if.data);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (!idle_on || stall_left == 0) begin
                res_if.ready <= 1'b1;
                if (idle_on) begin
                    if (run_left > 0) begin
                        run_left--;
                    end else begin
                        run_left   = $urandom_range(0, 40);
                        stall_left = $urandom_range(1, 16);
                    end
                end
            end else begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
        end
    end

    // Ends the run if neither channel moves a word for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ultrasonic_echo_ranger_core_tb failed");
        $finish;
    end

    function automatic t_cfg make_settings(logic [15:0] trig, logic [15:0] clear,
                                           logic [15:0] rise, logic [15:0] limit,
                                           logic [15:0] scale, logic [15:0] max_cm);
        t_cfg s;
        s.trigger_ticks      = trig;
        s.clear_ticks        = clear;
        s.rise_timeout_ticks = rise;
        s.echo_limit_ticks   = limit;
        s.cm_per_tick_q16    = scale;
        s.max_distance_cm    = max_cm;
        return s;
    endfunction

    // Short phases keep the measurements cheap; a wide setting lets the echo count run long
    // enough that the distance uses more of the product's upper half.
    function automatic t_cfg pick_settings(bit wide);
        t_cfg s;
        s.trigger_ticks      = 16'($urandom_range(0, 6));
        s.clear_ticks        = 16'($urandom_range(0, 6));
        s.rise_timeout_ticks = 16'($urandom_range(0, 12));
        s.echo_limit_ticks   = wide ? 16'($urandom_range(0, 400)) : 16'($urandom_range(0, 24));
        s.cm_per_tick_q16    = 16'($urandom);
        s.max_distance_cm    = $urandom_range(0, 1) ? 16'($urandom_range(0, 20)) : 16'($urandom);
        return s;
    endfunction

    // Presents one tick word, with a random gap in front of it when idling is on, and
    // holds it until the block takes it. valid stays high into the next word when no gap
    // follows, so it is never lowered and raised in the same step.
    task automatic send_tick(input t_in_word w);
        int gap;
        if (idle_on) begin
            if (send_run > 0) begin
                send_run--;
            end else begin
                send_run = $urandom_range(0, 40);
                gap      = $urandom_range(1, 16);
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do begin
            @(posedge clk);
        end while (!in_if.ready);
        ranger.take_tick(w);
        words_sent++;
    endtask

    // Drops valid and waits until every result word has come back and the pipeline is empty.
    task automatic settle();
        in_if.valid <= 1'b0;
        while (ranger.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        ranger.write_reg(idx, val);
    endtask

    // Writes all six registers on consecutive edges; the write enable drops only at the end.
    task automatic load_settings(t_cfg s);
        put_reg(REG_TRIGGER_TICKS, s.trigger_ticks);
        put_reg(REG_CLEAR_TICKS,   s.clear_ticks);
        put_reg(REG_RISE_TIMEOUT,  s.rise_timeout_ticks);
        put_reg(REG_ECHO_LIMIT,    s.echo_limit_ticks);
        put_reg(REG_CM_PER_TICK,   s.cm_per_tick_q16);
        put_reg(REG_MAX_DISTANCE,  s.max_distance_cm);
        cfg_we <= 1'b0;
    endtask

    // Idle ticks between measurements: no start, echo line wandering.
    task automatic idle_noise(int count);
        t_in_word w;
        for (int i = 0; i < count; i++) begin
            w.start_req = 1'b0;
            w.echo_in   = 1'(($urandom_range(0, 1)));
            send_tick(w);
        end
    endtask

    // One measurement from start to done. The echo line follows the sensor: it rises after
    // rise_delay low ticks of waiting and then stays high for high_len ticks. A delay past the
    // timeout or a pulse past the limit makes an error case. Starts sent while the block is
    // busy are random and must be ignored.
    task automatic run_measurement(bit start_echo, int rise_delay, int high_len);
        t_in_word w;
        int       waited;
        int       high_seen;
        bit       started;
        waited    = 0;
        high_seen = 0;
        started   = 1'b0;
        while (!started || ranger.phase != RANGE_IDLE) begin
            w.start_req = 1'(($urandom_range(0, 1)));
            w.echo_in   = 1'(($urandom_range(0, 1)));
            case (ranger.phase)
                RANGE_IDLE: begin
                    w.start_req = 1'b1;
                    w.echo_in   = start_echo;
                    started     = 1'b1;
                end
                RANGE_WAIT: begin
                    w.echo_in = (waited >= rise_delay);
                    waited++;
                end
                RANGE_COUNT: begin
                    w.echo_in = (high_seen < high_len);
                    high_seen++;
                end
                default: ;
            endcase
            send_tick(w);
        end
    endtask

    // Mostly well-formed echoes that land anywhere up to and on the timeout and the limit;
    // about one in five rises too late or stays high too long.
    task automatic random_measurement();
        int rise_delay;
        int high_len;
        int rise_max;
        int limit_max;
        rise_max  = ranger.regs.rise_timeout_ticks;
        limit_max = ranger.regs.echo_limit_ticks;
        rise_delay = ($urandom_range(0, 4) == 0) ? rise_max + $urandom_range(1, 3)
                                                 : $urandom_range(0, rise_max);
        high_len   = ($urandom_range(0, 4) == 0) ? limit_max + $urandom_range(1, 3)
                                                 : $urandom_range(0, limit_max);
        run_measurement(1'(($urandom_range(0, 1))), rise_delay, high_len);
    endtask

    initial begin : stimulus
        int first_random;
        int phase_start;
        int phase_no;
        cfg_we      <= 1'b0;
        cfg_idx     <= '0;
        cfg_wdata   <= '0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        rst_n       <= 1'b0;
        idle_on    = 1'b1;
        hold_req   = 1'b0;
        send_run   = 0;
        words_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Settings straight out of reset: 25-tick trigger, a short echo that scales to a
        // small distance.
        run_measurement(1'b0, 3, 300);

        // Zero trigger length gives a single trigger tick; the distance scale is at its
        // maximum and the clip value is tiny.
        settle();
        load_settings(make_settings(16'd0, 16'd3, 16'd4, 16'd5, 16'hFFFF, 16'd3));
        run_measurement(1'b1, 0, 2);   // stuck echo at start is driven low first
        run_measurement(1'b0, 4, 1);   // echo rises on the last tick before the timeout
        run_measurement(1'b0, 5, 1);   // echo never rises in time
        run_measurement(1'b0, 1, 5);   // count lands on the limit, distance is clipped
        run_measurement(1'b0, 1, 6);   // echo stays high past the limit
        run_measurement(1'b1, 0, 0);   // echo drops right after the rise tick

        // A stuck echo with no clear time skips the clear phase; zero timeout, zero limit,
        // zero scale and zero clip value.
        settle();
        load_settings(make_settings(16'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        run_measurement(1'b1, 0, 1);
        run_measurement(1'b0, 1, 0);
        run_measurement(1'b0, 0, 0);

        // Random phases, each with its own settings. The second one opens with a long
        // receiver hold while the sender keeps offering ticks.
        phase_no     = 0;
        first_random = words_sent;
        while (words_sent - first_random < RANDOM_WORDS) begin
            settle();
            load_settings(pick_settings(phase_no % 4 == 3));
            if (phase_no == 1)
                hold_req = 1'b1;
            phase_start = words_sent;
            while (words_sent - phase_start < 220) begin
                idle_noise($urandom_range(0, 3));
                random_measurement();
            end
            phase_no++;
        end

        // Limit, scale and clip value at full scale, with no idling on either side. The
        // distances stay below the clip value, and the last echo never rises in time.
        settle();
        idle_on = 1'b0;
        load_settings(make_settings(16'd3, 16'd2, 16'd40, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        run_measurement(1'b1, 5, 60);
        run_measurement(1'b0, 0, 30);
        run_measurement(1'b0, 50, 0);

        settle();
        if (ranger.failures == 0 && ranger.pending() == 0)
            $display("ultrasonic_echo_ranger_core_tb passed");
        else
            $display("ultrasonic_echo_ranger_core_tb failed");
        $finish;
    end

endmodule
